### design/calendar_date_counter_defines.svh
// assertion macros for the calendar date counter
// no dependencies, included by the top level
`ifndef CALENDAR_DATE_COUNTER_DEFINES_SVH
`define CALENDAR_DATE_COUNTER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CAL_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("calendar date counter: invariant violated");

// same-cycle implication
`define CAL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("calendar date counter: implication violated");

// next-cycle implication
`define CAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("calendar date counter: next-cycle check violated");

`endif

### design/cal_pkg.sv
// shared types, codes and calendar tables for the calendar date counter
// no dependencies
package cal_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int STEP_W  = 13;

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1900;
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2000;
    localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
    localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;

    // request kinds
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_ADVANCE = 2'd1;
    localparam logic [1:0] REQ_COMPARE = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_LIMIT   = 2'd2;

    // compare results, two's complement
    localparam logic [1:0] ORD_EARLIER = 2'b11;
    localparam logic [1:0] ORD_EQUAL   = 2'b00;
    localparam logic [1:0] ORD_LATER   = 2'b01;

    // x / 100 as (x * 5243) >> 19, exact for 14-bit x
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef struct packed {
        logic [7:0] quot;
        logic [6:0] rem;
        logic       leap;
    } div_res_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(2.6*m - 0.2) with m the month counted from march
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] term;
        case (month)
            4'd1:    term = 5'd28;
            4'd2:    term = 5'd31;
            4'd3:    term = 5'd2;
            4'd4:    term = 5'd5;
            4'd5:    term = 5'd7;
            4'd6:    term = 5'd10;
            4'd7:    term = 5'd12;
            4'd8:    term = 5'd15;
            4'd9:    term = 5'd18;
            4'd10:   term = 5'd20;
            4'd11:   term = 5'd23;
            4'd12:   term = 5'd25;
            default: term = 5'd0;
        endcase
        return term;
    endfunction

endpackage

### design/cal_div100.sv
// shared divide-by-100 unit: quotient, remainder and leap flag of a year
// two-stage pipeline, depends on cal_pkg
module cal_div100 (
    input  logic                      aclk,
    input  logic [cal_pkg::YEAR_W-1:0] x,
    output cal_pkg::div_res_t          res
);

    logic [26:0]                 prod_reg;
    logic [cal_pkg::YEAR_W-1:0]  x_reg;
    cal_pkg::div_res_t           res_reg;
    logic [7:0]                  quot;
    logic [cal_pkg::YEAR_W-1:0]  rem_wide;
    logic                        leap;

    assign quot     = prod_reg[cal_pkg::DIV100_SHIFT+7:cal_pkg::DIV100_SHIFT];
    assign rem_wide = x_reg - (14'(quot) * 14'd100);
    assign leap     = (rem_wide[6:0] == 7'd0) ? (quot[1:0] == 2'd0) : (x_reg[1:0] == 2'd0);

    always_ff @(posedge aclk) begin
        prod_reg     <= 27'(x) * 27'(cal_pkg::DIV100_RECIP);
        x_reg        <= x;
        res_reg.quot <= quot;
        res_reg.rem  <= rem_wide[6:0];
        res_reg.leap <= leap;
    end

    assign res = res_reg;

endmodule

### design/cal_day_step.sv
// one-day step of a gregorian date forward or backward, with range limits
// combinational, depends on cal_pkg
module cal_day_step #(
    parameter int YEAR_MAX = 9999
) (
    input  cal_pkg::date_t cur,
    input  logic           leap,
    input  logic           fwd,
    output cal_pkg::date_t nxt,
    output logic           at_limit
);

    logic [cal_pkg::DAY_W-1:0] cur_len;
    logic [cal_pkg::DAY_W-1:0] prev_len;

    assign cur_len  = cal_pkg::month_len(cur.month, leap);
    assign prev_len = cal_pkg::month_len(cur.month - 4'd1, leap);

    always_comb begin
        nxt = cur;
        if (fwd) begin
            at_limit = (cur.year >= 14'(YEAR_MAX)) && (cur.month >= 4'd12) && (cur.day >= 5'd31);
            if (cur.day >= cur_len) begin
                nxt.day = 5'd1;
                if (cur.month >= 4'd12) begin
                    nxt.month = 4'd1;
                    nxt.year  = cur.year + 14'd1;
                end else begin
                    nxt.month = cur.month + 4'd1;
                end
            end else begin
                nxt.day = cur.day + 5'd1;
            end
        end else begin
            at_limit = (cur.year <= cal_pkg::YEAR_MIN) && (cur.month <= 4'd1) && (cur.day <= 5'd1);
            if (cur.day <= 5'd1) begin
                if (cur.month <= 4'd1) begin
                    nxt.month = 4'd12;
                    nxt.year  = cur.year - 14'd1;
                    nxt.day   = 5'd31;
                end else begin
                    nxt.month = cur.month - 4'd1;
                    nxt.day   = prev_len;
                end
            end else begin
                nxt.day = cur.day - 5'd1;
            end
        end
    end

endmodule

### design/calendar_date_counter.sv
// calendar_date_counter top level: sequencer, stored date, weekday arithmetic
// uses cal_pkg, cal_div100, cal_day_step and calendar_date_counter_defines.svh
// load/advance: divider wait, then date check or day steps; other kinds go straight to weekday
// throughput: one request at a time, next beat taken once the sequencer is back in idle
// the stepping loop, the divider pipeline and a held result beat set how long a request takes
// aresetn (synchronous) sets the date to 2000-01-01 and empties the output register
`include "calendar_date_counter_defines.svh"

module calendar_date_counter #(
    parameter int YEAR_MAX = 9999,
    parameter int MAX_STEP = 4095
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // day, month, year, step_count
    input  logic [1:0]  s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // cur_day, cur_month, cur_year, weekday, order, status
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_W1,
        ST_DIV_W2,
        ST_LOAD,
        ST_STEP,
        ST_WK_W1,
        ST_WK_W2,
        ST_WK_SUM,
        ST_WK_MOD,
        ST_DONE
    } state_t;

    state_t                       state_reg;
    logic [1:0]                   req_reg;
    cal_pkg::date_t               in_date_reg;
    cal_pkg::date_t               date_reg;
    logic                         fwd_reg;
    logic [cal_pkg::STEP_W-1:0]   cnt_reg;
    logic [1:0]                   order_reg;
    logic [1:0]                   status_reg;
    logic [9:0]                   wk_sum_reg;
    logic [2:0]                   wk_day_reg;
    logic                         m_tvalid_reg;
    logic [31:0]                  m_tdata_reg;

    cal_pkg::date_t               in_date;
    logic [cal_pkg::STEP_W-1:0]   step_raw;
    logic [cal_pkg::STEP_W-1:0]   step_mag;
    logic [cal_pkg::STEP_W-1:0]   step_cnt;
    logic                         step_fwd;
    logic [1:0]                   cmp_order;
    logic [cal_pkg::YEAR_W-1:0]   div_x;
    cal_pkg::div_res_t            div_res;
    cal_pkg::date_t               step_nxt;
    logic                         step_limit;
    logic                         load_ok;
    logic [9:0]                   wk_sum;
    logic [16:0]                  wk_prod;
    logic [9:0]                   wk_rem_wide;
    logic [3:0]                   wk_rem;
    logic [2:0]                   wk_day;
    logic                         date_ok;
    logic                         step_go;

    // input beat fields
    assign in_date.day   = s_tdata[4:0];
    assign in_date.month = s_tdata[8:5];
    assign in_date.year  = s_tdata[22:9];
    assign step_raw      = s_tdata[35:23];

    assign step_fwd = !step_raw[cal_pkg::STEP_W-1] && (step_raw != '0);
    assign step_mag = step_raw[cal_pkg::STEP_W-1] ? (~step_raw + 13'd1) : step_raw;
    assign step_cnt = (32'(step_mag) > 32'(MAX_STEP)) ? 13'(MAX_STEP) : step_mag;

    always_comb begin
        if (date_reg.year != in_date.year) begin
            cmp_order = (date_reg.year < in_date.year) ? cal_pkg::ORD_EARLIER
                                                       : cal_pkg::ORD_LATER;
        end else if (date_reg.month != in_date.month) begin
            cmp_order = (date_reg.month < in_date.month) ? cal_pkg::ORD_EARLIER
                                                         : cal_pkg::ORD_LATER;
        end else if (date_reg.day != in_date.day) begin
            cmp_order = (date_reg.day < in_date.day) ? cal_pkg::ORD_EARLIER
                                                     : cal_pkg::ORD_LATER;
        end else begin
            cmp_order = cal_pkg::ORD_EQUAL;
        end
    end

    // operand of the shared divider
    always_comb begin
        case (state_reg)
            ST_DIV_W1, ST_DIV_W2, ST_LOAD: begin
                div_x = (req_reg == cal_pkg::REQ_LOAD) ? in_date_reg.year : date_reg.year;
            end
            ST_STEP: begin
                div_x = date_reg.year;
            end
            default: begin
                div_x = (date_reg.month < 4'd3) ? (date_reg.year - 14'd1) : date_reg.year;
            end
        endcase
    end

    cal_div100 u_div (
        .aclk (aclk),
        .x    (div_x),
        .res  (div_res)
    );

    // leap flag lags the year through the divider pipeline, year changes are far from february
    cal_day_step #(
        .YEAR_MAX (YEAR_MAX)
    ) u_step (
        .cur      (date_reg),
        .leap     (div_res.leap),
        .fwd      (fwd_reg),
        .nxt      (step_nxt),
        .at_limit (step_limit)
    );

    assign load_ok = (in_date_reg.year >= cal_pkg::YEAR_MIN)
                  && (in_date_reg.year <= 14'(YEAR_MAX))
                  && (in_date_reg.month >= 4'd1) && (in_date_reg.month <= 4'd12)
                  && (in_date_reg.day >= 5'd1)
                  && (in_date_reg.day <= cal_pkg::month_len(in_date_reg.month, div_res.leap));

    // weekday sum offset by 350 so it stays positive
    assign wk_sum = 10'd350 + 10'(date_reg.day) + 10'(cal_pkg::month_term(date_reg.month))
                  + 10'(div_res.rem) + 10'(div_res.rem[6:2]) + 10'(div_res.quot[7:2])
                  - 10'({div_res.quot, 1'b0});

    // mod 7 via reciprocal, quotient low by at most one
    assign wk_prod     = 17'(wk_sum_reg) * 17'd73;
    assign wk_rem_wide = wk_sum_reg - (10'(wk_prod[15:9]) * 10'd7);
    assign wk_rem      = wk_rem_wide[3:0];
    assign wk_day      = (wk_rem >= 4'd7) ? 3'(wk_rem - 4'd7) : wk_rem[2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            date_reg.day   <= cal_pkg::DAY_RESET;
            date_reg.month <= cal_pkg::MONTH_RESET;
            date_reg.year  <= cal_pkg::YEAR_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        req_reg     <= s_tuser;
                        in_date_reg <= in_date;
                        fwd_reg     <= step_fwd;
                        cnt_reg     <= step_cnt;
                        status_reg  <= cal_pkg::STAT_OK;
                        order_reg   <= (s_tuser == cal_pkg::REQ_COMPARE) ? cmp_order
                                                                         : cal_pkg::ORD_EQUAL;
                        if (s_tuser == cal_pkg::REQ_LOAD || s_tuser == cal_pkg::REQ_ADVANCE) begin
                            state_reg <= ST_DIV_W1;
                        end else begin
                            state_reg <= ST_WK_W1;
                        end
                    end
                end
                ST_DIV_W1: begin
                    state_reg <= ST_DIV_W2;
                end
                ST_DIV_W2: begin
                    state_reg <= (req_reg == cal_pkg::REQ_LOAD) ? ST_LOAD : ST_STEP;
                end
                ST_LOAD: begin
                    if (load_ok) begin
                        date_reg <= in_date_reg;
                    end else begin
                        status_reg <= cal_pkg::STAT_INVALID;
                    end
                    state_reg <= ST_WK_W1;
                end
                ST_STEP: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_WK_W1;
                    end else if (step_limit) begin
                        status_reg <= cal_pkg::STAT_LIMIT;
                        state_reg  <= ST_WK_W1;
                    end else begin
                        date_reg <= step_nxt;
                        cnt_reg  <= cnt_reg - 13'd1;
                    end
                end
                ST_WK_W1: begin
                    state_reg <= ST_WK_W2;
                end
                ST_WK_W2: begin
                    state_reg <= ST_WK_SUM;
                end
                ST_WK_SUM: begin
                    wk_sum_reg <= wk_sum;
                    state_reg  <= ST_WK_MOD;
                end
                ST_WK_MOD: begin
                    wk_day_reg <= wk_day;
                    state_reg  <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg[4:0]   <= date_reg.day;
                        m_tdata_reg[8:5]   <= date_reg.month;
                        m_tdata_reg[22:9]  <= date_reg.year;
                        m_tdata_reg[25:23] <= wk_day_reg;
                        m_tdata_reg[27:26] <= order_reg;
                        m_tdata_reg[29:28] <= status_reg;
                        m_tdata_reg[31:30] <= 2'b00;
                        m_tvalid_reg       <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign date_ok = (date_reg.year >= cal_pkg::YEAR_MIN) && (date_reg.year <= 14'(YEAR_MAX))
                  && (date_reg.month >= 4'd1) && (date_reg.month <= 4'd12)
                  && (date_reg.day >= 5'd1);
    assign step_go = (state_reg == ST_STEP) && (cnt_reg != 13'd0) && !step_limit;

    `CAL_ASSERT_ALWAYS(a_date_in_range, aclk, aresetn, date_ok)
    `CAL_ASSERT_NEXT(a_step_moves, aclk, aresetn, step_go, date_reg != $past(date_reg))
    `CAL_ASSERT_IMPL(a_weekday_range, aclk, aresetn, m_tvalid_reg, m_tdata_reg[25:23] != 3'd7)

endmodule

### bench/calendar_date_counter_tb.sv
// self-checking bench for calendar_date_counter: directed and random date requests
// checked beat by beat against an in-bench calendar predictor
// depends on cal_pkg and the calendar_date_counter rtl
module calendar_date_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int YEAR_TOP    = 9999;
    localparam int STEP_SAT    = 4095;
    localparam int IDLE_PCT    = 38;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [cal_pkg::DAY_W-1:0]   day;
        logic [cal_pkg::MONTH_W-1:0] month;
        logic [cal_pkg::YEAR_W-1:0]  year;
        logic [2:0]                  wday;
        logic [1:0]                  order;
        logic [1:0]                  status;
    } cal_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // day, month, year, step_count
    logic [1:0]  s_tuser  = '0;  // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // cur_day, cur_month, cur_year, weekday, order, status

    cal_pkg::date_t held_date = '{year: cal_pkg::YEAR_RESET, month: cal_pkg::MONTH_RESET,
                                  day: cal_pkg::DAY_RESET};
    cal_result_t expected_results[$];
    int          error_count   = 0;
    bit          tx_quiet      = 1'b0;
    bit          rx_quiet      = 1'b0;
    int          hold_request  = 0;

    calendar_date_counter #(
        .YEAR_MAX(YEAR_TOP),
        .MAX_STEP(STEP_SAT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit is_leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return is_leap_year(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // zeller style, months counted from march
    function automatic logic [2:0] weekday_of(cal_pkg::date_t dt);
        int yr, mp, yc, cent, s, r;
        yr = int'(dt.year);
        mp = int'(dt.month) - 2;
        if (dt.month < 3) begin
            yr = int'(dt.year) - 1;
            mp = int'(dt.month) + 10;
        end
        yc   = yr % 100;
        cent = yr / 100;
        s = int'(dt.day) + (26 * mp - 2) / 10 + yc + yc / 4 + cent / 4 - 2 * cent;
        r = s % 7;
        if (r < 0) r += 7;
        return r[2:0];
    endfunction

    function automatic bit step_one_day(bit fwd);
        if (fwd) begin
            if (held_date.year >= YEAR_TOP && held_date.month >= 12 && held_date.day >= 31)
                return 1'b0;
            if (held_date.day >= days_in_month(held_date.month, held_date.year)) begin
                held_date.day = 5'd1;
                if (held_date.month >= 12) begin
                    held_date.month = 4'd1;
                    held_date.year++;
                end else begin
                    held_date.month++;
                end
            end else begin
                held_date.day++;
            end
        end else begin
            if (held_date.year <= cal_pkg::YEAR_MIN && held_date.month <= 1 &&
                held_date.day <= 1)
                return 1'b0;
            if (held_date.day <= 1) begin
                if (held_date.month <= 1) begin
                    held_date.month = 4'd12;
                    held_date.year--;
                end else begin
                    held_date.month--;
                end
                held_date.day = 5'(days_in_month(held_date.month, held_date.year));
            end else begin
                held_date.day--;
            end
        end
        return 1'b1;
    endfunction

    function automatic cal_result_t predict_result(logic [1:0] kind, cal_pkg::date_t given,
                                                   logic signed [12:0] step);
        cal_result_t res;
        int          signed_step;
        int unsigned n;
        bit          fwd;
        bit          ok;
        res = '0;
        res.status = cal_pkg::STAT_OK;
        res.order  = cal_pkg::ORD_EQUAL;
        case (kind)
            cal_pkg::REQ_LOAD: begin
                ok = given.year >= cal_pkg::YEAR_MIN && given.year <= YEAR_TOP &&
                     given.month >= 1 && given.month <= 12 && given.day >= 1 &&
                     given.day <= days_in_month(given.month, given.year);
                if (ok) held_date = given;
                else    res.status = cal_pkg::STAT_INVALID;
            end
            cal_pkg::REQ_ADVANCE: begin
                signed_step = step;
                fwd = signed_step > 0;
                n = fwd ? signed_step : -signed_step;
                if (n > STEP_SAT) n = STEP_SAT;
                for (int unsigned i = 0; i < n; i++) begin
                    if (!step_one_day(fwd)) begin
                        res.status = cal_pkg::STAT_LIMIT;
                        break;
                    end
                end
            end
            cal_pkg::REQ_COMPARE: begin
                if (held_date.year != given.year)
                    res.order = (held_date.year < given.year) ? cal_pkg::ORD_EARLIER
                                                              : cal_pkg::ORD_LATER;
                else if (held_date.month != given.month)
                    res.order = (held_date.month < given.month) ? cal_pkg::ORD_EARLIER
                                                                : cal_pkg::ORD_LATER;
                else if (held_date.day != given.day)
                    res.order = (held_date.day < given.day) ? cal_pkg::ORD_EARLIER
                                                            : cal_pkg::ORD_LATER;
            end
            default: ;
        endcase
        res.day   = held_date.day;
        res.month = held_date.month;
        res.year  = held_date.year;
        res.wday  = weekday_of(held_date);
        return res;
    endfunction

    function automatic cal_pkg::date_t mk_date(int y, int m, int d);
        cal_pkg::date_t dt;
        dt.year  = cal_pkg::YEAR_W'(y);
        dt.month = cal_pkg::MONTH_W'(m);
        dt.day   = cal_pkg::DAY_W'(d);
        return dt;
    endfunction

    function automatic cal_pkg::date_t any_date();
        return mk_date($urandom_range(16383), $urandom_range(15), $urandom_range(31));
    endfunction

    function automatic cal_pkg::date_t valid_date();
        int y, m, d, r;
        r = $urandom_range(99);
        if (r < 10) begin
            y = YEAR_TOP;
            m = 12;
        end else if (r < 20) begin
            y = cal_pkg::YEAR_MIN;
            m = 1;
        end else begin
            y = (r < 35) ? 4 * $urandom_range(475, 2499)
                         : $urandom_range(cal_pkg::YEAR_MIN, YEAR_TOP);
            m = $urandom_range(1, 12);
        end
        d = ($urandom_range(99) < 30) ? days_in_month(m, y)
                                      : $urandom_range(1, days_in_month(m, y));
        if (r < 10) d = $urandom_range(20, 31);
        if (r >= 10 && r < 20) d = $urandom_range(1, 12);
        return mk_date(y, m, d);
    endfunction

    // mostly close to the held date so that every ordering shows up
    function automatic cal_pkg::date_t near_date();
        cal_pkg::date_t dt;
        dt = held_date;
        if ($urandom_range(3) == 0) return any_date();
        case ($urandom_range(3))
            1:       dt.day   = $urandom_range(1) ? dt.day + 5'd1 : dt.day - 5'd1;
            2:       dt.month = $urandom_range(1) ? dt.month + 4'd1 : dt.month - 4'd1;
            3:       dt.year  = $urandom_range(1) ? dt.year + 14'd1 : dt.year - 14'd1;
            default: ;
        endcase
        return dt;
    endfunction

    function automatic logic signed [12:0] rand_step();
        int r, mag;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r >= 88)
            return 13'($urandom);
        mag = (r < 70) ? $urandom_range(1, 60) : $urandom_range(61, 800);
        return $urandom_range(1) ? 13'(mag) : 13'(-mag);
    endfunction

    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            error_count++;
        end
    endfunction

    task automatic send_request(input logic [1:0] kind, input cal_pkg::date_t given,
                                input logic signed [12:0] step);
        while (!tx_quiet && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, step, given};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_results.push_back(predict_result(kind, given, step));
    endtask

    task automatic send_random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 22)
            send_request(cal_pkg::REQ_LOAD, valid_date(), 13'($urandom));
        else if (pick < 30)
            send_request(cal_pkg::REQ_LOAD, any_date(), 13'($urandom));
        else if (pick < 62)
            send_request(cal_pkg::REQ_ADVANCE, any_date(), rand_step());
        else if (pick < 92)
            send_request(cal_pkg::REQ_COMPARE, near_date(), 13'($urandom));
        else
            send_request(REQ_UNUSED, any_date(), 13'($urandom));
    endtask

    task automatic test_reset_state();
        send_request(cal_pkg::REQ_COMPARE, mk_date(2000, 1, 1), '0);
        send_request(REQ_UNUSED, any_date(), 13'($urandom));
    endtask

    task automatic test_load_checks();
        send_request(cal_pkg::REQ_LOAD, mk_date(1900, 1, 1), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(9999, 12, 31), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(2000, 2, 29), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(1900, 2, 29), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(2100, 2, 29), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(2024, 4, 31), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(2024, 0, 10), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(2024, 13, 1), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(2024, 5, 0), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(1899, 12, 31), 13'($urandom));
        send_request(cal_pkg::REQ_LOAD, mk_date(16383, 15, 31), 13'($urandom));
    endtask

    task automatic test_advance_limits();
        send_request(cal_pkg::REQ_LOAD, mk_date(9999, 12, 25), '0);
        send_request(cal_pkg::REQ_ADVANCE, any_date(), 13'sd10);
        send_request(cal_pkg::REQ_ADVANCE, any_date(), 13'sd0);
        send_request(cal_pkg::REQ_LOAD, mk_date(1900, 1, 5), '0);
        send_request(cal_pkg::REQ_ADVANCE, any_date(), -13'sd20);
        send_request(cal_pkg::REQ_LOAD, mk_date(1999, 12, 31), '0);
        send_request(cal_pkg::REQ_ADVANCE, any_date(), 13'sd1);
        send_request(cal_pkg::REQ_ADVANCE, any_date(), -13'sd1);
        send_request(cal_pkg::REQ_ADVANCE, any_date(), 13'h1000);
        send_request(cal_pkg::REQ_ADVANCE, any_date(), 13'h0FFF);
    endtask

    task automatic test_compare_order();
        send_request(cal_pkg::REQ_COMPARE, mk_date(16383, 15, 31), 13'($urandom));
        send_request(cal_pkg::REQ_COMPARE, mk_date(0, 0, 0), 13'($urandom));
    endtask

    task automatic test_back_to_back();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        repeat (25) send_random_request();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_output_hold();
        hold_request = 400;
        tx_quiet = 1'b1;
        repeat (6) send_random_request();
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_mix();
        repeat (84) send_random_request();
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_quiet) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : result_check
        cal_result_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = '{day: m_tdata[4:0], month: m_tdata[8:5], year: m_tdata[22:9],
                        wday: m_tdata[25:23], order: m_tdata[27:26],
                        status: m_tdata[29:28]};
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, got %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("cur_day", want.day, got.day);
                    check_field("cur_month", want.month, got.month);
                    check_field("cur_year", want.year, got.year);
                    check_field("weekday", want.wday, got.wday);
                    check_field("order", want.order, got.order);
                    check_field("status", want.status, got.status);
                end
            end
        end
    end

    initial begin : stall_watch
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("calendar_date_counter_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_load_checks();
        test_advance_limits();
        test_compare_order();
        test_back_to_back();
        test_output_hold();
        test_random_mix();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("calendar_date_counter_tb: done, clean");
        else
            $display("calendar_date_counter_tb: done, errors");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/cal_pkg.sv
design/cal_div100.sv
design/cal_day_step.sv
design/calendar_date_counter.sv
bench/calendar_date_counter_tb.sv
